FILE: rtl/textured_span_mapper_assert.svh
// Assertion macros for the span mapper RTL.
`ifndef TEXTURED_SPAN_MAPPER_ASSERT_SVH
`define TEXTURED_SPAN_MAPPER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TSM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define TSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TSM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define TSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/tsm_pkg.sv
// Shared constants, field layout and inter-module types of the span mapper.
package tsm_pkg;

   localparam int unsigned SCREEN_WIDTH  = 320;
   localparam int unsigned SCREEN_HEIGHT = 200;
   localparam int unsigned FRAC_BITS     = 8;
   localparam int unsigned QUEUE_DEPTH   = 4;

   localparam int unsigned COL_W  = 9;
   localparam int unsigned ROW_W  = 8;
   localparam int unsigned DST_W  = 11;
   localparam int unsigned LEN_W  = 10;
   localparam int unsigned ADDR_W = 16;
   localparam int unsigned MAG_W  = COL_W + FRAC_BITS;
   localparam int unsigned ACC_W  = MAG_W + 1;
   localparam int unsigned POS_W  = ACC_W - FRAC_BITS;
   localparam int unsigned OFS_W  = 17;

   // Input transfer layout, lowest bit first.
   localparam int unsigned REQ_X1_LSB   = 0;
   localparam int unsigned REQ_Y1_LSB   = REQ_X1_LSB + COL_W;
   localparam int unsigned REQ_X2_LSB   = REQ_Y1_LSB + ROW_W;
   localparam int unsigned REQ_Y2_LSB   = REQ_X2_LSB + COL_W;
   localparam int unsigned REQ_DX_LSB   = REQ_Y2_LSB + ROW_W;
   localparam int unsigned REQ_DY_LSB   = REQ_DX_LSB + DST_W;
   localparam int unsigned REQ_LEN_LSB  = REQ_DY_LSB + DST_W;
   localparam int unsigned REQ_USED_W   = REQ_LEN_LSB + LEN_W;
   localparam int unsigned REQ_DATA_W   = ((REQ_USED_W + 7) / 8) * 8;
   localparam int unsigned RSP_DATA_W   = 2 * ADDR_W;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_STEP  = 1'b1;

   typedef struct packed {
      logic             is_start;
      logic             span_ok;
      logic             x_neg;
      logic [COL_W-1:0] x_mag;
      logic             y_neg;
      logic [ROW_W-1:0] y_mag;
      logic [COL_W-1:0] x_base;
      logic [ROW_W-1:0] y_base;
      logic [LEN_W-1:0] length;
      logic [LEN_W-1:0] pixels;
      logic [DST_W-1:0] col;
      logic [OFS_W-1:0] offset;
   } tsm_cmd_type;

   typedef struct packed {
      logic             start;
      logic             x_neg;
      logic [MAG_W-1:0] x_num;
      logic             y_neg;
      logic [MAG_W-1:0] y_num;
      logic [LEN_W-1:0] den;
   } tsm_div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [ACC_W-1:0] x_quo;
      logic [ACC_W-1:0] y_quo;
   } tsm_div_rsp_type;

endpackage

FILE: rtl/tsm_front.sv
// Front end: decodes an input transfer into a command, doing the span setup checks.
module tsm_front (
   input  logic                      action,
   input  logic [tsm_pkg::COL_W-1:0] src_x_start,
   input  logic [tsm_pkg::ROW_W-1:0] src_y_start,
   input  logic [tsm_pkg::COL_W-1:0] src_x_end,
   input  logic [tsm_pkg::ROW_W-1:0] src_y_end,
   input  logic [tsm_pkg::DST_W-1:0] dst_x,
   input  logic [tsm_pkg::DST_W-1:0] dst_y,
   input  logic [tsm_pkg::LEN_W-1:0] span_length,
   output tsm_pkg::tsm_cmd_type      cmd
);
   import tsm_pkg::*;

   localparam logic [DST_W:0] LAST_COL = (DST_W + 1)'(SCREEN_WIDTH - 1);
   localparam logic [DST_W-2:0] LAST_ROW = (DST_W - 1)'(SCREEN_HEIGHT - 1);

   logic [COL_W:0]   dx;
   logic [ROW_W:0]   dy;
   logic [COL_W:0]   dx_abs;
   logic [ROW_W:0]   dy_abs;
   logic [DST_W:0]   xd_ext;
   logic [DST_W:0]   end_col;
   logic [DST_W:0]   clip_len;
   logic [DST_W:0]   eff_len;
   logic             clip;
   logic             row_ok;
   logic             eff_ok;
   logic [OFS_W-1:0] row_base;

   always_comb begin
      dx     = {1'b0, src_x_end} - {1'b0, src_x_start};
      dy     = {1'b0, src_y_end} - {1'b0, src_y_start};
      dx_abs = dx[COL_W] ? -dx : dx;
      dy_abs = dy[ROW_W] ? -dy : dy;

      row_ok  = !dst_y[DST_W-1] && (dst_y[DST_W-2:0] <= LAST_ROW);
      xd_ext  = {dst_x[DST_W-1], dst_x};
      end_col = xd_ext + {1'b0, {(DST_W - LEN_W){1'b0}}, span_length};
      // The right edge clips one column early: the last screen column stays untouched.
      clip     = $signed(end_col) > $signed(LAST_COL);
      clip_len = LAST_COL - xd_ext;
      eff_len  = clip ? clip_len : {1'b0, {(DST_W - LEN_W){1'b0}}, span_length};
      eff_ok   = !eff_len[DST_W] && (eff_len != '0);

      row_base = OFS_W'(dst_y[ROW_W-1:0]) * OFS_W'(SCREEN_WIDTH);

      cmd.is_start = (action == ACTION_START);
      cmd.span_ok  = row_ok && (span_length != '0) && eff_ok;
      cmd.x_neg    = dx[COL_W];
      cmd.x_mag    = dx_abs[COL_W-1:0];
      cmd.y_neg    = dy[ROW_W];
      cmd.y_mag    = dy_abs[ROW_W-1:0];
      cmd.x_base   = src_x_start;
      cmd.y_base   = src_y_start;
      cmd.length   = span_length;
      cmd.pixels   = eff_len[LEN_W-1:0];
      cmd.col      = dst_x;
      cmd.offset   = row_base + {{(OFS_W - DST_W){dst_x[DST_W-1]}}, dst_x};
   end

endmodule

FILE: rtl/tsm_queue.sv
// Command queue between the front end and the back end.
module tsm_queue #(
   parameter int unsigned DEPTH = tsm_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tsm_pkg::tsm_cmd_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 valid,
   output tsm_pkg::tsm_cmd_type pop_data
);
   import tsm_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tsm_cmd_type      slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/tsm_div.sv
// Restoring divider: both span steps in parallel, one quotient bit per cycle.
module tsm_div (
   input  logic                     clock,
   input  logic                     reset,
   input  tsm_pkg::tsm_div_req_type req,
   output tsm_pkg::tsm_div_rsp_type rsp
);
   import tsm_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAG_W + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] count_ff;
   logic             done;
   logic             x_neg_ff;
   logic             y_neg_ff;
   logic [LEN_W-1:0] den_ff;
   logic [LEN_W-1:0] x_rem_ff;
   logic [LEN_W-1:0] y_rem_ff;
   logic [MAG_W-1:0] x_quo_ff;
   logic [MAG_W-1:0] y_quo_ff;
   logic [LEN_W+MAG_W-1:0] x_next;
   logic [LEN_W+MAG_W-1:0] y_next;

   // One restoring step: shift in the next dividend bit, subtract when it fits.
   function automatic logic [LEN_W+MAG_W-1:0] div_step(
      input logic [LEN_W-1:0] rem,
      input logic [MAG_W-1:0] quo,
      input logic [LEN_W-1:0] den
   );
      logic [LEN_W:0]   shifted;
      logic [LEN_W+1:0] diff;
      logic             fits;
      shifted = {rem, quo[MAG_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den};
      fits    = !diff[LEN_W+1];
      return {fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0], quo[MAG_W-2:0], fits};
   endfunction

   assign done   = busy_ff && (count_ff == CNT_W'(MAG_W));
   assign x_next = div_step(x_rem_ff, x_quo_ff, den_ff);
   assign y_next = div_step(y_rem_ff, y_quo_ff, den_ff);

   assign rsp.busy  = busy_ff;
   assign rsp.done  = done;
   assign rsp.x_quo = x_neg_ff ? -{1'b0, x_quo_ff} : {1'b0, x_quo_ff};
   assign rsp.y_quo = y_neg_ff ? -{1'b0, y_quo_ff} : {1'b0, y_quo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (req.start) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
      end else if (done) begin
         busy_ff  <= 1'b0;
      end else if (busy_ff) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         x_neg_ff <= req.x_neg;
         y_neg_ff <= req.y_neg;
         den_ff   <= req.den;
         x_rem_ff <= '0;
         y_rem_ff <= '0;
         x_quo_ff <= req.x_num;
         y_quo_ff <= req.y_num;
      end else if (busy_ff && !done) begin
         x_rem_ff <= x_next[LEN_W+MAG_W-1:MAG_W];
         x_quo_ff <= x_next[MAG_W-1:0];
         y_rem_ff <= y_next[LEN_W+MAG_W-1:MAG_W];
         y_quo_ff <= y_next[MAG_W-1:0];
      end
   end

endmodule

FILE: rtl/tsm_back.sv
// Back end: span setup, the fixed-point stepper and the registered result stage.
module tsm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  tsm_pkg::tsm_cmd_type              cmd,
   output logic                              q_pop,
   output tsm_pkg::tsm_div_req_type          div_req,
   input  tsm_pkg::tsm_div_rsp_type          div_rsp,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tsm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import tsm_pkg::*;

   typedef enum logic {
      ST_RUN,
      ST_DIVIDE
   } state_type;

   state_type         state_ff, state_in;
   logic              active_ff, active_in;
   logic [ACC_W-1:0]  x_pos_ff, x_pos_in;
   logic [ACC_W-1:0]  y_pos_ff, y_pos_in;
   logic [ACC_W-1:0]  x_step_ff, x_step_in;
   logic [ACC_W-1:0]  y_step_ff, y_step_in;
   logic [LEN_W-1:0]  pixels_ff, pixels_in;
   logic [DST_W-1:0]  col_ff, col_in;
   logic [OFS_W-1:0]  offset_ff, offset_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] src_addr_ff, src_addr_in;
   logic [ADDR_W-1:0] dst_addr_ff, dst_addr_in;
   logic              write_ff, write_in;
   logic              last_ff, last_in;

   logic              out_free;
   logic [POS_W-1:0]  src_row;
   logic [POS_W-1:0]  src_col;
   logic [ADDR_W-1:0] src_addr;
   logic              is_last;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_pop    = q_valid && (state_ff == ST_RUN) && (cmd.is_start || out_free);

   assign div_req.start = q_pop && cmd.is_start && cmd.span_ok;
   assign div_req.x_neg = cmd.x_neg;
   assign div_req.x_num = {cmd.x_mag, {FRAC_BITS{1'b0}}};
   assign div_req.y_neg = cmd.y_neg;
   assign div_req.y_num = MAG_W'({cmd.y_mag, {FRAC_BITS{1'b0}}});
   assign div_req.den   = cmd.length;

   // The position registers already hold the accumulator advanced by one step,
   // so the address of the pixel being emitted comes straight from them.
   assign src_row  = y_pos_ff[ACC_W-1:FRAC_BITS];
   assign src_col  = x_pos_ff[ACC_W-1:FRAC_BITS];
   assign src_addr = {{(ADDR_W - POS_W){src_row[POS_W-1]}}, src_row} * ADDR_W'(SCREEN_WIDTH)
                   + {{(ADDR_W - POS_W){src_col[POS_W-1]}}, src_col};
   assign is_last  = (pixels_ff <= LEN_W'(1));

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      x_pos_in     = x_pos_ff;
      y_pos_in     = y_pos_ff;
      x_step_in    = x_step_ff;
      y_step_in    = y_step_ff;
      pixels_in    = pixels_ff;
      col_in       = col_ff;
      offset_in    = offset_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      src_addr_in  = src_addr_ff;
      dst_addr_in  = dst_addr_ff;
      write_in     = write_ff;
      last_in      = last_ff;

      unique case (state_ff)
         ST_RUN: begin
            if (q_pop && cmd.is_start) begin
               active_in = 1'b0;
               if (cmd.span_ok) begin
                  x_pos_in  = ACC_W'({cmd.x_base, {FRAC_BITS{1'b0}}});
                  y_pos_in  = ACC_W'({cmd.y_base, {FRAC_BITS{1'b0}}});
                  pixels_in = cmd.pixels;
                  col_in    = cmd.col;
                  offset_in = cmd.offset;
                  state_in  = ST_DIVIDE;
               end
            end else if (q_pop && active_ff) begin
               rsp_valid_in = 1'b1;
               src_addr_in  = src_addr;
               write_in     = !col_ff[DST_W-1];
               dst_addr_in  = col_ff[DST_W-1] ? '0 : offset_ff[ADDR_W-1:0];
               last_in      = is_last;
               x_pos_in     = x_pos_ff + x_step_ff;
               y_pos_in     = y_pos_ff + y_step_ff;
               pixels_in    = pixels_ff - 1'b1;
               col_in       = col_ff + 1'b1;
               offset_in    = offset_ff + 1'b1;
               if (is_last) begin
                  active_in = 1'b0;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               x_step_in = div_rsp.x_quo;
               y_step_in = div_rsp.y_quo;
               x_pos_in  = x_pos_ff + div_rsp.x_quo;
               y_pos_in  = y_pos_ff + div_rsp.y_quo;
               active_in = 1'b1;
               state_in  = ST_RUN;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_pos_ff    <= x_pos_in;
      y_pos_ff    <= y_pos_in;
      x_step_ff   <= x_step_in;
      y_step_ff   <= y_step_in;
      pixels_ff   <= pixels_in;
      col_ff      <= col_in;
      offset_ff   <= offset_in;
      src_addr_ff <= src_addr_in;
      dst_addr_ff <= dst_addr_in;
      write_ff    <= write_in;
      last_ff     <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {dst_addr_ff, src_addr_ff};
   assign rsp_tuser  = write_ff;
   assign rsp_tlast  = last_ff;

endmodule

FILE: rtl/textured_span_mapper.sv
// Top level of the affine texture span mapper.
// A start transfer (tuser 0) sets up a span and produces no result; each step
// transfer (tuser 1) on an active span produces one pixel result, at one per
// cycle while the output accepts results. A start whose span is empty or
// clipped away does not start the divider. For a real span the restoring
// divider develops the two signed 10.8 steps in parallel, one quotient bit per
// cycle over 17 bits, before the first step is served. A four-entry command
// queue keeps accepting transfers while the divider runs; while a result waits
// in the result register, start transfers are still taken but steps stall.
`include "textured_span_mapper_assert.svh"

module textured_span_mapper #(
   parameter int unsigned QUEUE_DEPTH = tsm_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // src_x_start, src_y_start, src_x_end, src_y_end, dst_x, dst_y, span_length
   input  logic [tsm_pkg::REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // src_addr, dst_addr
   output logic [tsm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // write_pixel
   output logic                           rsp_tuser,
   output logic                           rsp_tlast
);
   import tsm_pkg::*;

   tsm_cmd_type     front_cmd;
   tsm_cmd_type     q_cmd;
   logic            q_full;
   logic            q_valid;
   logic            q_pop;
   tsm_div_req_type div_req;
   tsm_div_rsp_type div_rsp;

   assign req_tready = !q_full;

   tsm_front u_front (
      .action      (req_tuser),
      .src_x_start (req_tdata[REQ_X1_LSB +: COL_W]),
      .src_y_start (req_tdata[REQ_Y1_LSB +: ROW_W]),
      .src_x_end   (req_tdata[REQ_X2_LSB +: COL_W]),
      .src_y_end   (req_tdata[REQ_Y2_LSB +: ROW_W]),
      .dst_x       (req_tdata[REQ_DX_LSB +: DST_W]),
      .dst_y       (req_tdata[REQ_DY_LSB +: DST_W]),
      .span_length (req_tdata[REQ_LEN_LSB +: LEN_W]),
      .cmd         (front_cmd)
   );

   tsm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_cmd)
   );

   tsm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   tsm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .cmd        (q_cmd),
      .q_pop      (q_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `TSM_ASSERT_IMPLY(a_start_idle, clock, reset, div_req.start, !div_rsp.busy, "divider busy")
   `TSM_ASSERT_IMPLY(a_no_pop_busy, clock, reset, div_rsp.busy, !q_pop, "pop while dividing")
   `TSM_ASSERT_IMPLY(a_rsp_pop, clock, reset, $rose(rsp_tvalid), $past(q_pop), "stray result")
   `TSM_ASSERT_NEXT(a_done_idle, clock, reset, div_rsp.done, !div_rsp.busy, "busy after done")

endmodule
